// ===== rtl/tdt_pkg.sv =====
// shared types and codes for the texel decode and tint pipeline
package tdt_pkg;

    // source formats
    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_RGB5A3 = 2'd1;
    localparam logic [1:0] FMT_RGBA8  = 2'd2;
    localparam logic [1:0] FMT_BLOCK  = 2'd3;

    // configuration register indexes
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_TINT   = 1'b1;

    // reset values
    localparam logic [1:0]  FORMAT_RESET = FMT_RGB565;
    localparam logic [23:0] TINT_RESET   = 24'hFF_FFFF;

    // colour triple, index 2 red, 1 green, 0 blue (matches tint byte order)
    typedef logic [2:0][7:0] t_rgb;

    // how the colour of a decoded texel is finished in the next stage
    typedef enum logic [1:0] {
        MIX_DIRECT = 2'd0,
        MIX_HALF   = 2'd1,
        MIX_THIRD  = 2'd2
    } t_mix;

    typedef struct packed {
        t_mix            mix;
        logic [2:0][9:0] num;
        t_rgb            rgb;
        logic [7:0]      alpha;
    } t_dec;

endpackage

// ===== rtl/tdt_decode.sv =====
// texel format decode: channel expansion and block palette numerators
module tdt_decode
    import tdt_pkg::*;
(
    input  logic [1:0]  i_format,
    input  logic [15:0] i_texel_word,
    input  logic [15:0] i_second_endpoint,
    input  logic [1:0]  i_palette_index,
    input  logic [7:0]  i_raw_red,
    input  logic [7:0]  i_raw_green,
    input  logic [7:0]  i_raw_blue,
    input  logic [7:0]  i_raw_alpha,
    output t_dec        o_dec
);

    // v*255/31 = 8v + floor(7v/31)
    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [2:0] k;
        k = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
          + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + {5'b0, k};
    endfunction

    // v*255/63 = 4v + floor(v/21)
    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [1:0] k;
        k = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + {6'b0, k};
    endfunction

    // v*255/7 = 36v + floor(3v/7)
    function automatic logic [7:0] exp3(input logic [2:0] v);
        logic [1:0] k;
        k = 2'(v >= 3'd3) + 2'(v >= 3'd5) + 2'(v >= 3'd7);
        return {v, 5'b0} + {3'b0, v, 2'b00} + {6'b0, k};
    endfunction

    function automatic t_rgb dec565(input logic [15:0] v);
        return {exp5(v[15:11]), exp6(v[10:5]), exp5(v[4:0])};
    endfunction

    t_rgb w_ep0;
    t_rgb w_ep1;
    logic w_four;

    assign w_ep0  = dec565(i_texel_word);
    assign w_ep1  = dec565(i_second_endpoint);
    assign w_four = i_texel_word > i_second_endpoint;

    always_comb begin
        o_dec       = '0;
        o_dec.mix   = MIX_DIRECT;
        o_dec.alpha = 8'hFF;
        unique case (i_format)
            FMT_RGB565: begin
                o_dec.rgb = w_ep0;
            end
            FMT_RGB5A3: begin
                if (i_texel_word[15]) begin
                    o_dec.rgb = {exp5(i_texel_word[14:10]), exp5(i_texel_word[9:5]),
                                 exp5(i_texel_word[4:0])};
                end else begin
                    o_dec.rgb   = {i_texel_word[11:8], i_texel_word[11:8],
                                   i_texel_word[7:4], i_texel_word[7:4],
                                   i_texel_word[3:0], i_texel_word[3:0]};
                    o_dec.alpha = exp3(i_texel_word[14:12]);
                end
            end
            FMT_RGBA8: begin
                o_dec.rgb   = {i_raw_red, i_raw_green, i_raw_blue};
                o_dec.alpha = i_raw_alpha;
            end
            FMT_BLOCK: begin
                unique case (i_palette_index)
                    2'd0: o_dec.rgb = w_ep0;
                    2'd1: o_dec.rgb = w_ep1;
                    2'd2: begin
                        o_dec.mix = w_four ? MIX_THIRD : MIX_HALF;
                        for (int c = 0; c < 3; c++) begin
                            o_dec.num[c] = (w_four ? {1'b0, w_ep0[c], 1'b0}
                                                   : {2'b00, w_ep0[c]})
                                         + {2'b00, w_ep1[c]};
                        end
                    end
                    2'd3: begin
                        if (w_four) begin
                            o_dec.mix = MIX_THIRD;
                            for (int c = 0; c < 3; c++) begin
                                o_dec.num[c] = {2'b00, w_ep0[c]} + {1'b0, w_ep1[c], 1'b0};
                            end
                        end else begin
                            // transparent black entry
                            o_dec.alpha = 8'h00;
                        end
                    end
                endcase
            end
        endcase
    end

endmodule

// ===== rtl/texel_decode_and_tint_top.sv =====
// top level: six-stage texel decode, luminance and overlay tint pipeline
//
// Takes one texel per beat and returns one tinted RGBA8 pixel per beat. The
// pipeline accepts a new texel every clock cycle unless every stage is full
// and the output is stalled. The six register stages, in order, are format
// decode, palette blend, luminance sum, luminance scaling, overlay product
// and the divide by 255 into the output register. Each stage holds a valid
// bit and moves on when the stage after it is free, so a stalled output only
// stops the stages that are full and empty slots are filled in the meantime.
// Format and tint are written through the configuration port; the format
// applies to texels taken after the write and the tint to pixels reaching
// the overlay product stage after it; write them while no pixels are in flight.
module texel_decode_and_tint_top
    import tdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_texel_word,
    input  logic [15:0] i_second_endpoint,
    input  logic [1:0]  i_palette_index,
    input  logic [7:0]  i_raw_red,
    input  logic [7:0]  i_raw_green,
    input  logic [7:0]  i_raw_blue,
    input  logic [7:0]  i_raw_alpha,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);

    localparam int         STAGES       = 6;
    localparam logic [9:0]  THIRD_RECIP  = 10'd683;       // 2^11 / 3, rounded up
    localparam logic [23:0] LUM_RECIP    = 24'd13743896;  // 2^37 / 10000, rounded up
    localparam logic [17:0] DIV255_RECIP = 18'd131587;    // 2^25 / 255, rounded up
    localparam logic [13:0] LUMA_R       = 14'd2126;
    localparam logic [13:0] LUMA_G       = 14'd7152;
    localparam logic [13:0] LUMA_B       = 14'd722;
    localparam logic [21:0] LUMA_ROUND   = 22'd5000;

    logic [1:0]        r_format;
    logic [23:0]       r_tint;
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] adv;

    t_dec              n_dec,  r_dec;
    t_rgb              n_px,   r_px;
    logic [21:0]       n_sum,  r_sum;
    logic [7:0]        n_lum,  r_lum;
    logic [2:0][15:0]  n_prod, r_prod;
    logic              n_lo,   r_lo;
    t_rgb              n_out,  r_out;
    logic [7:0]        r_alpha1, r_alpha2, r_alpha3, r_alpha4, r_alpha5;

    logic [2:0][19:0]  w_third;
    logic [45:0]       w_lum_prod;
    logic [2:0][33:0]  w_quot;
    logic [6:0]        w_f;
    t_rgb              w_g;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FORMAT_RESET;
            r_tint   <= TINT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FORMAT: r_format <= i_cfg_data[1:0];
                REG_TINT:   r_tint   <= i_cfg_data;
            endcase
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb begin
        adv[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: format decode
    tdt_decode u_decode (
        .i_format          (r_format),
        .i_texel_word      (i_texel_word),
        .i_second_endpoint (i_second_endpoint),
        .i_palette_index   (i_palette_index),
        .i_raw_red         (i_raw_red),
        .i_raw_green       (i_raw_green),
        .i_raw_blue        (i_raw_blue),
        .i_raw_alpha       (i_raw_alpha),
        .o_dec             (n_dec)
    );

    // stage 1: palette blend, divide by three by reciprocal
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_third[c] = 20'(r_dec.num[c]) * 20'(THIRD_RECIP);
            case (r_dec.mix)
                MIX_THIRD: n_px[c] = w_third[c][18:11];
                MIX_HALF:  n_px[c] = r_dec.num[c][8:1];
                default:   n_px[c] = r_dec.rgb[c];
            endcase
        end
    end

    // stage 2: weighted luminance sum
    assign n_sum = 22'(r_px[2]) * 22'(LUMA_R) + 22'(r_px[1]) * 22'(LUMA_G)
                 + 22'(r_px[0]) * 22'(LUMA_B) + LUMA_ROUND;

    // stage 3: divide by 10000
    assign w_lum_prod = 46'(r_sum) * 46'(LUM_RECIP);
    assign n_lum      = w_lum_prod[44:37];

    // stage 4: overlay products, dark half scales the tint, light half screens it
    assign n_lo = !r_lum[7];
    assign w_f  = n_lo ? r_lum[6:0] : ~r_lum[6:0];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_g[c]    = n_lo ? r_tint[c*8 +: 8] : ~r_tint[c*8 +: 8];
            n_prod[c] = 16'({w_f, 1'b0}) * 16'(w_g[c]) + 16'd127;
        end
    end

    // stage 5: divide by 255 and fold back the light half
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_quot[c] = 34'(r_prod[c]) * 34'(DIV255_RECIP);
            n_out[c]  = r_lo ? w_quot[c][32:25] : ~w_quot[c][32:25];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_valid) begin
            r_dec <= n_dec;
        end
        if (adv[1] && r_v[0]) begin
            r_px     <= n_px;
            r_alpha1 <= r_dec.alpha;
        end
        if (adv[2] && r_v[1]) begin
            r_sum    <= n_sum;
            r_alpha2 <= r_alpha1;
        end
        if (adv[3] && r_v[2]) begin
            r_lum    <= n_lum;
            r_alpha3 <= r_alpha2;
        end
        if (adv[4] && r_v[3]) begin
            r_prod   <= n_prod;
            r_lo     <= n_lo;
            r_alpha4 <= r_alpha3;
        end
        if (adv[5] && r_v[4]) begin
            r_out    <= n_out;
            r_alpha5 <= r_alpha4;
        end
    end

    assign o_out_red   = r_out[2];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[0];
    assign o_out_alpha = r_alpha5;

`ifndef SYNTHESIS
    // input back-pressure only when every stage is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v))
        else $error("input stalled with an empty stage");

    // a held beat in the decode stage is not dropped
    a_hold_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !adv[0]) |=> r_v[0])
        else $error("decode stage beat lost while stalled");

    // interpolated entries of the four-colour palette are always opaque
    a_third_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && r_dec.mix == MIX_THIRD) |-> (r_dec.alpha == 8'hFF))
        else $error("interpolated entry not opaque");

    // overlay products stay within the divide-by-255 reciprocal range
    a_prod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> (r_prod[0] <= 16'd64897 && r_prod[1] <= 16'd64897
                    && r_prod[2] <= 16'd64897))
        else $error("overlay product out of range");
`endif

endmodule

// ===== verif/texel_decode_and_tint_top_tb.sv =====
// testbench for the texel decode and tint pipeline: queued texels, own pixel predictor, checker
`timescale 1ns / 100ps

module texel_decode_and_tint_top_tb;
    import tdt_pkg::*;

    localparam int unsigned PHASES        = 12;
    localparam int unsigned PHASE_TEXELS  = 110;
    localparam int unsigned HOLD_AT       = 520;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned STUCK_LIMIT   = 2000;

    typedef struct packed {
        logic [15:0] word;
        logic [15:0] end1;
        logic [1:0]  sel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_texel;

    // index 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][7:0] t_rgba;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_FORMAT;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_texel_word = '0;
    logic [15:0] i_second_endpoint = '0;
    logic [1:0]  i_palette_index = '0;
    logic [7:0]  i_raw_red = '0;
    logic [7:0]  i_raw_green = '0;
    logic [7:0]  i_raw_blue = '0;
    logic [7:0]  i_raw_alpha = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;

    t_texel      pending_texels [$];
    t_rgba       expected_pixels [$];
    logic [1:0]  fmt_cfg = FORMAT_RESET;
    logic [23:0] tint_cfg = TINT_RESET;
    bit          calm = 1'b0;
    int unsigned pixels_seen = 0;
    int unsigned error_count = 0;

    texel_decode_and_tint_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_texel_word      (i_texel_word),
        .i_second_endpoint (i_second_endpoint),
        .i_palette_index   (i_palette_index),
        .i_raw_red         (i_raw_red),
        .i_raw_green       (i_raw_green),
        .i_raw_blue        (i_raw_blue),
        .i_raw_alpha       (i_raw_alpha),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_red         (o_out_red),
        .o_out_green       (o_out_green),
        .o_out_blue        (o_out_blue),
        .o_out_alpha       (o_out_alpha)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_rgba decode565(logic [15:0] v);
        t_rgba px;
        px[0] = 8'(v[15:11] * 255 / 31);
        px[1] = 8'(v[10:5] * 255 / 63);
        px[2] = 8'(v[4:0] * 255 / 31);
        px[3] = 8'hFF;
        return px;
    endfunction

    function automatic t_rgba predict_pixel(t_texel tx, logic [1:0] fmt, logic [23:0] tint);
        t_rgba       px;
        t_rgba       ep0;
        t_rgba       ep1;
        bit          four;
        int unsigned lum;
        int unsigned t;
        int          c;
        case (fmt)
            FMT_RGB565: px = decode565(tx.word);
            FMT_RGB5A3: begin
                if (tx.word[15]) begin
                    px[0] = 8'(tx.word[14:10] * 255 / 31);
                    px[1] = 8'(tx.word[9:5] * 255 / 31);
                    px[2] = 8'(tx.word[4:0] * 255 / 31);
                    px[3] = 8'hFF;
                end else begin
                    px[0] = 8'(tx.word[11:8] * 17);
                    px[1] = 8'(tx.word[7:4] * 17);
                    px[2] = 8'(tx.word[3:0] * 17);
                    px[3] = 8'(tx.word[14:12] * 255 / 7);
                end
            end
            FMT_RGBA8: px = {tx.alpha, tx.blue, tx.green, tx.red};
            default: begin
                ep0 = decode565(tx.word);
                ep1 = decode565(tx.end1);
                // four-colour palette only when the first endpoint word is larger
                four = tx.word > tx.end1;
                case (tx.sel)
                    2'd0: px = ep0;
                    2'd1: px = ep1;
                    2'd2: begin
                        for (c = 0; c < 3; c++)
                            px[c] = four ? 8'((2 * ep0[c] + ep1[c]) / 3)
                                         : 8'((ep0[c] + ep1[c]) / 2);
                        px[3] = 8'hFF;
                    end
                    default: begin
                        for (c = 0; c < 3; c++)
                            px[c] = four ? 8'((ep0[c] + 2 * ep1[c]) / 3) : 8'h00;
                        px[3] = four ? 8'hFF : 8'h00;
                    end
                endcase
            end
        endcase
        lum = (2126 * px[0] + 7152 * px[1] + 722 * px[2] + 5000) / 10000;
        for (c = 0; c < 3; c++) begin
            t = {24'd0, tint[(2 - c) * 8 +: 8]};
            if (lum < 128)
                px[c] = 8'((2 * lum * t + 127) / 255);
            else
                px[c] = 8'(255 - (2 * (255 - lum) * (255 - t) + 127) / 255);
        end
        return px;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_texel random_texel(logic [1:0] fmt);
        t_texel      tx;
        logic [15:0] swap;
        int unsigned pick;
        logic [7:0]  grey;
        tx.word  = 16'($urandom_range(0, 65535));
        tx.end1  = 16'($urandom_range(0, 65535));
        tx.sel   = 2'($urandom_range(0, 3));
        tx.red   = 8'($urandom_range(0, 255));
        tx.green = 8'($urandom_range(0, 255));
        tx.blue  = 8'($urandom_range(0, 255));
        tx.alpha = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 3);
        if (fmt == FMT_BLOCK) begin
            // push toward the three-colour palette so it comes up more often than the four-colour one
            if (pick == 0) begin
                tx.end1 = tx.word;
            end else if (pick == 1 && tx.word > tx.end1) begin
                swap = tx.word;
                tx.word = tx.end1;
                tx.end1 = swap;
            end
        end else if (fmt == FMT_RGBA8 && pick == 0) begin
            // greys either side of the overlay switch-over
            grey = 8'($urandom_range(118, 138));
            tx.red = grey;
            tx.green = grey;
            tx.blue = grey;
        end
        return tx;
    endfunction

    task automatic queue_texel(logic [15:0] w, logic [15:0] e, logic [1:0] s,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        pending_texels.push_back({w, e, s, r, g, b, a});
    endtask

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FORMAT)
            fmt_cfg = data[1:0];
        else
            tint_cfg = data;
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_texels.size() != 0 || i_valid || expected_pixels.size() != 0);
    endtask

    // sender
    always @(posedge i_clk) begin : texel_driver
        t_texel      on_pins;
        int unsigned in_gap;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_pixels.push_back(predict_pixel(on_pins, fmt_cfg, tint_cfg));
                in_gap = pick_gap();
            end
            if (!i_valid || o_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (pending_texels.size() != 0) begin
                    on_pins = pending_texels.pop_front();
                    i_texel_word      <= on_pins.word;
                    i_second_endpoint <= on_pins.end1;
                    i_palette_index   <= on_pins.sel;
                    i_raw_red         <= on_pins.red;
                    i_raw_green       <= on_pins.green;
                    i_raw_blue        <= on_pins.blue;
                    i_raw_alpha       <= on_pins.alpha;
                    i_valid           <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each pixel beat and drives ready
    always @(posedge i_clk) begin : pixel_monitor
        t_rgba       want;
        bit          beat;
        bit          hold_done;
        int unsigned hold_left;
        int unsigned out_stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_done = 1'b0;
            hold_left = 0;
            out_stall = 0;
        end else begin
            beat = o_valid && i_ready;
            if (beat) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel with none expected: %h %h %h %h",
                        o_out_red, o_out_green, o_out_blue, o_out_alpha));
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_red !== want[0])
                        report_mismatch($sformatf("pixel %0d out_red %h, want %h",
                            pixels_seen, o_out_red, want[0]));
                    if (o_out_green !== want[1])
                        report_mismatch($sformatf("pixel %0d out_green %h, want %h",
                            pixels_seen, o_out_green, want[1]));
                    if (o_out_blue !== want[2])
                        report_mismatch($sformatf("pixel %0d out_blue %h, want %h",
                            pixels_seen, o_out_blue, want[2]));
                    if (o_out_alpha !== want[3])
                        report_mismatch($sformatf("pixel %0d out_alpha %h, want %h",
                            pixels_seen, o_out_alpha, want[3]));
                end
                pixels_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && pixels_seen == HOLD_AT) begin
                // long back-pressure mid-phase so the pipeline fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (beat)
                    out_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int unsigned stuck;
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck = 0;
        end else begin
            stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [1:0]  fmt;
        logic [23:0] tint;
        int unsigned ph;
        int unsigned n;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: rgb565 under a white tint
        queue_texel(16'h0000, 16'hFFFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_texel(16'hFFFF, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'hF800, 16'h1234, 2'd1, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
        queue_texel(16'h07E0, 16'h0000, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h001F, 16'hFFFF, 2'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // rgb5a3: opaque and translucent forms, black tint
        write_reg(REG_FORMAT, {22'd0, FMT_RGB5A3});
        write_reg(REG_TINT, 24'h000000);
        queue_texel(16'hFFFF, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h8000, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h7FFF, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h0000, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h7000, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h0ABC, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // raw rgba8, including greys on both sides of the luminance threshold
        write_reg(REG_FORMAT, {22'd0, FMT_RGBA8});
        write_reg(REG_TINT, 24'h7F80FF);
        queue_texel(16'h0000, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h0000, 16'h0000, 2'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_texel(16'h0000, 16'h0000, 2'd0, 8'h7F, 8'h7F, 8'h7F, 8'h55);
        queue_texel(16'h0000, 16'h0000, 2'd0, 8'h80, 8'h80, 8'h80, 8'hAA);
        queue_texel(16'h0000, 16'h0000, 2'd0, 8'hFF, 8'h00, 8'h00, 8'h80);
        wait_idle();

        // compressed block: four-colour, equal endpoints and three-colour palettes
        write_reg(REG_FORMAT, {22'd0, FMT_BLOCK});
        write_reg(REG_TINT, 24'h00FF80);
        queue_texel(16'hFFFF, 16'h0000, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'hFFFF, 16'h0000, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'hFFFF, 16'h0000, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'hFFFF, 16'h0000, 2'd3, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h1234, 16'h1234, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h1234, 16'h1234, 2'd3, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h0000, 16'hFFFF, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(16'h0000, 16'hFFFF, 2'd3, 8'h00, 8'h00, 8'h00, 8'h00);

        for (ph = 0; ph < PHASES; ph++) begin
            // stimulus waits for every outstanding pixel before touching the registers
            wait_idle();
            fmt = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
            case (ph)
                0: tint = 24'h000000;
                1: tint = 24'hFFFFFF;
                2: tint = 24'hFF00FF;
                default: tint = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            // spare bits of the format write are don't-care
            write_reg(REG_FORMAT, {22'($urandom_range(0, 22'h3FFFFF)), fmt});
            write_reg(REG_TINT, tint);
            calm = (ph % 5 == 3);
            for (n = 0; n < PHASE_TEXELS; n++)
                pending_texels.push_back(random_texel(fmt));
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== texel_decode_and_tint_top.f =====
rtl/tdt_pkg.sv
rtl/tdt_decode.sv
rtl/texel_decode_and_tint_top.sv
verif/texel_decode_and_tint_top_tb.sv
